FILE: src/tdts_pkg.sv
// Package for the TDMA deadline transmit scheduler: types, constants, codes.
// No dependencies.
`default_nettype none
package tdts_pkg;
    localparam int MAX_MSGS_DEF    = 16;
    localparam int FRAME_BYTES_DEF = 8;
    localparam int MASK_SLOTS_DEF  = 60;

    localparam logic [6:0] SPC_RESET = 7'd60;

    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_ONAIR   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    localparam logic [1:0] REG_SPC  = 2'd0;
    localparam logic [1:0] REG_MASK = 2'd1;

    localparam logic ACT_RESERVE = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // in tdata: msg_id, msg_size, period, first_slot, cycle, slot_in_cycle
    localparam int IN_W  = 16 + 8 + 16 + 32 + 16 + 6;
    localparam int IN_TW = ((IN_W + 7) / 8) * 8;
    // out tdata: accepted, frame_valid, frame_id, frame_offset, frame_len,
    //            msg_status, slot_reserved
    localparam int OUT_W  = 1 + 1 + 23 + 8 + 4 + 2 + 1;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic        action;
        logic [15:0] msg_id;
        logic [7:0]  msg_size;
        logic [15:0] period;
        logic [31:0] first_slot;
        logic [15:0] cycle;
        logic [5:0]  slot_in_cycle;
    } cmd_t;

    typedef struct packed {
        logic        accepted;
        logic        frame_valid;
        logic [22:0] frame_id;
        logic [7:0]  frame_offset;
        logic [3:0]  frame_len;
        logic [1:0]  msg_status;
        logic        slot_reserved;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

FILE: src/tdts_front.sv
// Front end: accepts stream items, unpacks fields, and queues commands.
// Depends on tdts_pkg.
`default_nettype none
module tdts_front
    import tdts_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             in_action,
    input  wire logic [IN_TW-1:0] in_data,
    output logic                  q_valid,
    input  wire logic             q_pop,
    output cmd_t                  q_cmd
);
    localparam int DEPTH = 2;

    cmd_t       mem_reg [DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    cmd_t       cin;
    logic       push;

    always_comb
    begin
        cin.action        = in_action;
        cin.msg_id        = in_data[15:0];
        cin.msg_size      = in_data[23:16];
        cin.period        = in_data[39:24];
        cin.first_slot    = in_data[71:40];
        cin.cycle         = in_data[87:72];
        cin.slot_in_cycle = in_data[93:88];
    end

    assign in_ready = (cnt_reg != 2'(DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= cin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop && q_valid)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end
endmodule
`default_nettype wire

FILE: src/tdts_back.sv
// Back end: message table, head scan over one entry per cycle, tick and
// reserve execution, output register. Depends on tdts_pkg.
`default_nettype none
module tdts_back
    import tdts_pkg::*;
#(
    parameter int MAX_MSGS    = MAX_MSGS_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int MASK_SLOTS  = MASK_SLOTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    output logic             q_pop,
    input  wire cmd_t        q_cmd,
    input  wire logic [6:0]  spc,
    input  wire logic [63:0] mask,
    output logic             out_valid,
    input  wire logic        out_ready,
    output res_t             out_res
);
    localparam int IW = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;
    localparam int CW = $clog2(MAX_MSGS + 1);

    logic [MAX_MSGS-1:0] valid_reg;
    logic [15:0] ident_mem [MAX_MSGS];
    logic [31:0] dl_mem    [MAX_MSGS];
    logic [15:0] per_mem   [MAX_MSGS];
    logic [7:0]  size_mem  [MAX_MSGS];
    logic [7:0]  frag_mem  [MAX_MSGS];
    logic [7:0]  off_mem   [MAX_MSGS];
    logic [1:0]  stat_mem  [MAX_MSGS];
    logic [31:0] age_mem   [MAX_MSGS];
    logic [31:0] ins_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [IW-1:0] best_reg, best_next;
    logic best_ok_reg, best_ok_next;
    logic [31:0] best_dl_reg, best_dl_next, best_di_reg, best_di_next;
    logic [31:0] now_reg, now_next;
    res_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;

    logic [IW-1:0] cur;
    logic [31:0]   di;
    logic          better;
    logic [IW-1:0] free_idx;
    logic          free_ok;
    logic [31:0]   hdl;
    logic [8:0]    hsz;
    logic [32:0]   wend;
    logic          in_win, has_frag;
    logic [7:0]    hoff;
    logic [7:0]    len;
    logic [5:0]    sic;

    function automatic logic [7:0] frag_count(input logic [7:0] s);
        logic [7:0] r;
        r = (s != 8'd0) ? 8'((s - 8'd1) / FRAME_BYTES) : 8'd0;
        return r;
    endfunction

    assign cur = idx_reg[IW-1:0];
    assign di  = ins_reg - age_mem[cur];
    always_comb
    begin
        better = 1'b0;
        if (valid_reg[cur])
        begin
            if (!best_ok_reg || dl_mem[cur] < best_dl_reg)
            begin
                better = 1'b1;
            end
            else if (dl_mem[cur] == best_dl_reg && di > best_di_reg)
            begin
                better = 1'b1;
            end
        end
    end

    always_comb
    begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = MAX_MSGS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign hdl      = dl_mem[best_reg];
    assign hsz      = {1'b0, size_mem[best_reg]};
    assign hoff     = off_mem[best_reg];
    assign wend     = {1'b0, hdl} + 33'(hsz);
    assign in_win   = ({1'b0, now_reg} < wend);
    assign has_frag = (frag_mem[best_reg] != 8'd0);
    assign len      = (size_mem[best_reg] >= hoff) ? size_mem[best_reg] - hoff : 8'd0;
    assign sic      = q_cmd.slot_in_cycle;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        best_ok_next   = best_ok_reg;
        best_dl_next   = best_dl_reg;
        best_di_next   = best_di_reg;
        now_next       = now_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        q_pop          = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !out_valid_next)
                begin
                    res_next            = '0;
                    res_next.msg_status = ST_NONE;
                    if (q_cmd.action == ACT_RESERVE)
                    begin
                        res_next.accepted = free_ok;
                        q_pop             = 1'b1;
                        out_valid_next    = 1'b1;
                    end
                    else
                    begin
                        now_next = 32'(q_cmd.cycle) * 32'(spc) + 32'(sic);
                        if (32'(sic) < 32'(MASK_SLOTS))
                        begin
                            res_next.slot_reserved = mask[sic];
                        end
                        idx_next     = '0;
                        best_ok_next = 1'b0;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (better)
                begin
                    best_next    = cur;
                    best_ok_next = 1'b1;
                    best_dl_next = dl_mem[cur];
                    best_di_next = di;
                end
                idx_next = idx_reg + CW'(1);
                if (idx_reg == CW'(MAX_MSGS - 1))
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (best_ok_reg)
                begin
                    res_next.msg_status = stat_mem[best_reg];
                    if (now_reg >= hdl)
                    begin
                        if (in_win)
                        begin
                            res_next.frame_valid  = 1'b1;
                            res_next.frame_id     = {ident_mem[best_reg],
                                                     frag_mem[best_reg][6:0]};
                            res_next.frame_offset = hoff;
                            if (has_frag)
                            begin
                                res_next.frame_len  = 4'(FRAME_BYTES);
                                res_next.msg_status = ST_ONAIR;
                            end
                            else
                            begin
                                res_next.frame_len  = len[3:0];
                                res_next.msg_status = ST_READY;
                            end
                        end
                        else
                        begin
                            res_next.msg_status = ST_TIMEOUT;
                        end
                    end
                end
                q_pop          = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid && !(out_valid_reg && !out_ready)
            && q_cmd.action == ACT_RESERVE && free_ok)
        begin
            ident_mem[free_idx] <= q_cmd.msg_id;
            size_mem[free_idx]  <= q_cmd.msg_size;
            per_mem[free_idx]   <= q_cmd.period;
            dl_mem[free_idx]    <= q_cmd.first_slot;
            frag_mem[free_idx]  <= frag_count(q_cmd.msg_size);
            off_mem[free_idx]   <= 8'd0;
            stat_mem[free_idx]  <= ST_READY;
            age_mem[free_idx]   <= ins_reg;
        end
        else if (state_reg == S_EXEC && best_ok_reg && now_reg >= hdl)
        begin
            if (in_win && has_frag)
            begin
                frag_mem[best_reg] <= frag_mem[best_reg] - 8'd1;
                off_mem[best_reg]  <= hoff + 8'(FRAME_BYTES);
                stat_mem[best_reg] <= ST_ONAIR;
            end
            else
            begin
                stat_mem[best_reg] <= in_win ? ST_READY : ST_TIMEOUT;
                off_mem[best_reg]  <= 8'd0;
                frag_mem[best_reg] <= frag_count(size_mem[best_reg]);
                dl_mem[best_reg]   <= hdl + 32'(per_mem[best_reg]);
                age_mem[best_reg]  <= ins_reg;
            end
        end
        best_reg    <= best_next;
        best_dl_reg <= best_dl_next;
        best_di_reg <= best_di_next;
        now_reg     <= now_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            best_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            ins_reg       <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            best_ok_reg   <= best_ok_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_IDLE && q_valid && !(out_valid_reg && !out_ready)
                && q_cmd.action == ACT_RESERVE && free_ok)
            begin
                valid_reg[free_idx] <= 1'b1;
                ins_reg             <= ins_reg + 32'd1;
            end
            else if (state_reg == S_EXEC && best_ok_reg && now_reg >= hdl
                     && !(in_win && has_frag))
            begin
                ins_reg <= ins_reg + 32'd1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;
endmodule
`default_nettype wire

FILE: src/tdma_deadline_transmit_scheduler.sv
// Time-triggered transmit calendar: holds up to MAX_MSGS periodic messages
// and serves them by deadline (ties by insertion age). A reserve item is
// handled from the idle state; a tick item runs the head search, which reads
// one table entry per cycle, then the execute and output states. A two-entry
// command queue sits in front, and the registered result can wait while the
// next item is queued. Depends on tdts_pkg, tdts_front and tdts_back.
`default_nettype none
module tdma_deadline_transmit_scheduler
    import tdts_pkg::*;
#(
    parameter int MAX_MSGS    = MAX_MSGS_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int MASK_SLOTS  = MASK_SLOTS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // msg_id, msg_size, period, first_slot, cycle, slot_in_cycle, zero pad
    input  wire logic [IN_TW-1:0]  s_tdata,
    // action
    input  wire logic              s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // accepted, frame_valid, frame_id, frame_offset, frame_len, msg_status,
    // slot_reserved
    output logic [OUT_TW-1:0]      m_tdata,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [63:0]       pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);
    logic [6:0]  spc_reg;
    logic [63:0] mask_reg;
    logic        q_valid, q_pop;
    cmd_t        q_cmd;
    res_t        res;
    logic        out_valid;
    logic        wr;
    logic [1:0]  ridx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[3] ? REG_MASK : REG_SPC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spc_reg  <= SPC_RESET;
            mask_reg <= 64'd0;
        end
        else if (wr && paddr[2:0] == 3'd0)
        begin
            if (ridx == REG_SPC)
            begin
                spc_reg <= pwdata[6:0];
            end
            else
            begin
                mask_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        case (ridx)
            REG_SPC:  prdata = {57'd0, spc_reg};
            REG_MASK: prdata = mask_reg;
            default:  prdata = 64'd0;
        endcase
    end

    tdts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_data   (s_tdata),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd)
    );

    tdts_back #(
        .MAX_MSGS    (MAX_MSGS),
        .FRAME_BYTES (FRAME_BYTES),
        .MASK_SLOTS  (MASK_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .spc       (spc_reg),
        .mask      (mask_reg),
        .out_valid (out_valid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {res.slot_reserved, res.msg_status, res.frame_len,
                       res.frame_offset, res.frame_id, res.frame_valid,
                       res.accepted};
endmodule
`default_nettype wire
